### design/g2g_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// g2g_pkg
// Shared constants, types and helpers of the go-to-goal controller.
// ---------------------------------------------------------------------------
package g2g_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 12;
    localparam int ATAN_LEN         = 24;
    localparam int CW               = 40;

    localparam logic [2:0] REG_TARGET_X   = 3'd0;
    localparam logic [2:0] REG_TARGET_Y   = 3'd1;
    localparam logic [2:0] REG_DIST_KP    = 3'd2;
    localparam logic [2:0] REG_DIST_KI    = 3'd3;
    localparam logic [2:0] REG_DIST_KD    = 3'd4;
    localparam logic [2:0] REG_HEAD_KP    = 3'd5;
    localparam logic [2:0] REG_HEAD_KI    = 3'd6;
    localparam logic [2:0] REG_HEAD_KD    = 3'd7;

    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [33:0]   z;
    } t_cvec;

    typedef struct packed {
        logic [33:0] n;
        logic [33:0] r;
    } t_sq;

    function automatic logic signed [33:0] atan_q30(input int i);
        case (i)
            0: atan_q30 = 34'sd843314857;
            1: atan_q30 = 34'sd497837829;
            2: atan_q30 = 34'sd263043837;
            3: atan_q30 = 34'sd133525159;
            4: atan_q30 = 34'sd67021687;
            5: atan_q30 = 34'sd33543516;
            6: atan_q30 = 34'sd16775851;
            7: atan_q30 = 34'sd8388437;
            8: atan_q30 = 34'sd4194283;
            9: atan_q30 = 34'sd2097149;
            10: atan_q30 = 34'sd1048576;
            11: atan_q30 = 34'sd524288;
            12: atan_q30 = 34'sd262144;
            13: atan_q30 = 34'sd131072;
            14: atan_q30 = 34'sd65536;
            15: atan_q30 = 34'sd32768;
            16: atan_q30 = 34'sd16384;
            17: atan_q30 = 34'sd8192;
            18: atan_q30 = 34'sd4096;
            19: atan_q30 = 34'sd2048;
            20: atan_q30 = 34'sd1024;
            21: atan_q30 = 34'sd512;
            22: atan_q30 = 34'sd256;
            23: atan_q30 = 34'sd128;
            default: atan_q30 = 34'sd0;
        endcase
    endfunction

endpackage

### design/g2g_cordic_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// g2g_cordic_cell
// One vectoring CORDIC micro-rotation, registered, handed to the next cell.
// ---------------------------------------------------------------------------
module g2g_cordic_cell
    import g2g_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cvec i_v,
    output t_cvec o_v
);

    t_cvec r_v;
    t_cvec n_v;

    always_comb begin
        if (i_v.y >= 0) begin
            n_v.x = i_v.x + (i_v.y >>> STEP);
            n_v.y = i_v.y - (i_v.x >>> STEP);
            n_v.z = i_v.z + ((STEP < ATAN_LEN) ? atan_q30(STEP) : 34'sd0);
        end else begin
            n_v.x = i_v.x - (i_v.y >>> STEP);
            n_v.y = i_v.y + (i_v.x >>> STEP);
            n_v.z = i_v.z - ((STEP < ATAN_LEN) ? atan_q30(STEP) : 34'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;

endmodule

### design/g2g_sqrt_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// g2g_sqrt_cell
// One restoring square-root digit step, registered, handed to the next cell.
// ---------------------------------------------------------------------------
module g2g_sqrt_cell
    import g2g_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_sq  i_s,
    output t_sq  o_s
);

    localparam logic [33:0] BIT = 34'd1 << (32 - 2 * STEP);

    t_sq r_s;
    t_sq n_s;

    always_comb begin
        if (i_s.n >= i_s.r + BIT) begin
            n_s.n = i_s.n - (i_s.r + BIT);
            n_s.r = (i_s.r >> 1) + BIT;
        end else begin
            n_s.n = i_s.n;
            n_s.r = i_s.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

### design/go_to_goal_pid_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// go_to_goal_pid_controller
// Bearing and distance to a target by a chain of CORDIC and square-root
// cells, then two PID loops with saturating integrators.
// ---------------------------------------------------------------------------
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    pose_x, pose_y, heading
// m_axis    out  m_axis_tvalid/m_axis_tready    speeds, distance, error, reached
// cfg       in   i_cfg_valid/o_cfg_ready        index, 16-bit value
// Steps: the CORDIC and square-root chains run side by side, then the error
// is captured, the products formed, summed, and the output register loaded.
// A new item is taken only after the last one has reached the output register.
// Reset restores register defaults and clears the loop state.
// A waiting result holds; the next item stops in its last step until it is
// taken, and the input stays off meanwhile.
// ---------------------------------------------------------------------------
module go_to_goal_pid_controller
    import g2g_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] pose_x, [31:16] pose_y, [46:32] heading
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [23:0] linear_speed, [47:24] angular_speed, [63:48] distance,
    // [79:64] heading_error, [80] reached
    output logic [87:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SQ_STEPS = 17;
    localparam int CHAIN    = (CORDIC_STEPS > SQ_STEPS) ? CORDIC_STEPS : SQ_STEPS;
    localparam int CNT_W    = $clog2(CHAIN + 8);
    localparam logic signed [16:0] THR_A = 17'((5 * (1 << FRAC_BITS) + 50) / 100);
    localparam logic [16:0] THR_D = 17'((10 * (1 << FRAC_BITS) + 50) / 100);

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_ANG, S_MUL, S_SUM, S_OUT} t_state;

    t_state r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0] r_tx, r_ty;
    logic signed [15:0] r_dkp, r_dki, r_dkd, r_hkp, r_hki, r_hkd;
    logic [15:0] r_prev_d;
    logic signed [31:0] r_dsum;
    logic signed [15:0] r_prev_e;
    logic signed [31:0] r_esum;
    logic signed [14:0] r_th;
    logic r_zero;
    logic [15:0] r_dist;
    logic signed [15:0] r_err;
    logic signed [47:0] r_p [6];
    logic signed [49:0] r_lacc, r_aacc;
    logic r_ovalid;
    logic [87:0] r_odata;

    t_cvec cv [CORDIC_STEPS+1];
    t_sq   sq [SQ_STEPS+1];
    t_cvec r_cv0;
    t_sq   r_sq0;
    logic  chain_en;

    assign chain_en = (r_state == S_RUN);
    assign cv[0] = r_cv0;
    assign sq[0] = r_sq0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cord
        g2g_cordic_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_en(chain_en), .i_v(cv[g]), .o_v(cv[g+1]));
    end
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        g2g_sqrt_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_en(chain_en), .i_s(sq[g]), .o_s(sq[g+1]));
    end

    logic signed [16:0] dx, dy;
    logic signed [CW-1:0] x0, y0;
    logic [33:0] d2;
    logic signed [33:0] zr;
    logic signed [16:0] bear, ediff;
    logic signed [15:0] err_s;
    logic [15:0] dist_s;
    logic signed [16:0] ddd, ded;
    logic signed [32:0] dsum_n, esum_n;
    logic signed [49:0] lsh, ash;
    logic signed [23:0] lin, ang;
    logic reached;

    assign dx = $signed({1'b0, r_tx}) - $signed({1'b0, s_axis_tdata[15:0]});
    assign dy = $signed({1'b0, r_ty}) - $signed({1'b0, s_axis_tdata[31:16]});
    assign x0 = CW'(dx) <<< 14;
    assign y0 = CW'(dy) <<< 14;
    assign d2 = 34'(unsigned'(32'(dx * dx))) + 34'(unsigned'(32'(dy * dy)));

    assign zr = cv[CORDIC_STEPS].z + (34'sd1 <<< (29 - FRAC_BITS));
    assign bear = r_zero ? 17'sd0 : 17'(zr >>> (30 - FRAC_BITS));
    assign ediff = bear - 17'(r_th);
    assign err_s = (ediff > 17'sd32767) ? 16'sh7fff :
                   (ediff < -17'sd32768) ? 16'sh8000 : 16'(ediff);
    assign dist_s = (sq[SQ_STEPS].r > 34'd65535) ? 16'hffff : 16'(sq[SQ_STEPS].r);

    assign ddd = $signed({1'b0, r_dist}) - $signed({1'b0, r_prev_d});
    assign ded = 17'(r_err) - 17'(r_prev_e);
    assign dsum_n = 33'(r_dsum) + $signed({17'd0, r_dist});
    assign esum_n = 33'(r_esum) + 33'(r_err);
    assign lsh = r_lacc >>> FRAC_BITS;
    assign ash = r_aacc >>> FRAC_BITS;
    assign lin = (lsh > 50'sd8388607) ? 24'sh7fffff :
                 (lsh < -50'sd8388608) ? 24'sh800000 : 24'(lsh);
    assign ang = (ash > 50'sd8388607) ? 24'sh7fffff :
                 (ash < -50'sd8388608) ? 24'sh800000 : 24'(ash);
    assign reached = (17'(r_err) > -THR_A) && (17'(r_err) < THR_A) &&
                     ({1'b0, r_dist} < THR_D);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
            r_tx <= 16'd22528;
            r_ty <= 16'd22528;
            r_dkp <= 16'sd1229;
            r_dki <= 16'sd0;
            r_dkd <= 16'sd410;
            r_hkp <= 16'sd4096;
            r_hki <= 16'sd0;
            r_hkd <= 16'sd0;
            r_prev_d <= '0;
            r_dsum <= '0;
            r_prev_e <= '0;
            r_esum <= '0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TARGET_X: r_tx <= i_cfg_data;
                    REG_TARGET_Y: r_ty <= i_cfg_data;
                    REG_DIST_KP:  r_dkp <= i_cfg_data;
                    REG_DIST_KI:  r_dki <= i_cfg_data;
                    REG_DIST_KD:  r_dkd <= i_cfg_data;
                    REG_HEAD_KP:  r_hkp <= i_cfg_data;
                    REG_HEAD_KI:  r_hki <= i_cfg_data;
                    REG_HEAD_KD:  r_hkd <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_th <= s_axis_tdata[46:32];
                        r_zero <= (dx == 0) && (dy == 0);
                        r_sq0.n <= d2;
                        r_sq0.r <= '0;
                        if (x0 < 0) begin
                            r_cv0.x <= -x0;
                            r_cv0.y <= -y0;
                            r_cv0.z <= (y0 >= 0) ? PI_Q30 : -PI_Q30;
                        end else begin
                            r_cv0.x <= x0;
                            r_cv0.y <= y0;
                            r_cv0.z <= '0;
                        end
                        r_cnt <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(CHAIN - 1)) begin
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    r_dist <= dist_s;
                    r_err <= err_s;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p[0] <= 48'(r_dkp * $signed({1'b0, r_dist}));
                    r_p[1] <= 48'(r_dkd * ddd);
                    r_p[2] <= 48'(r_dki * r_dsum);
                    r_p[3] <= 48'(r_hkp * r_err);
                    r_p[4] <= 48'(r_hkd * ded);
                    r_p[5] <= 48'(r_hki * r_esum);
                    r_prev_d <= r_dist;
                    r_prev_e <= r_err;
                    r_dsum <= (dsum_n > 33'sh07fffffff) ? 32'sh7fffffff : 32'(dsum_n);
                    r_esum <= (esum_n > 33'sh07fffffff) ? 32'sh7fffffff :
                              (esum_n < -33'sh080000000) ? 32'sh80000000 : 32'(esum_n);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_lacc <= 50'(r_p[0]) + 50'(r_p[1]) + 50'(r_p[2]);
                    r_aacc <= 50'(r_p[3]) + 50'(r_p[4]) + 50'(r_p[5]);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata <= {7'd0, reached, r_err, r_dist, ang, lin};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### test/go_to_goal_pid_controller_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// go_to_goal_pid_controller_test
// Streams pose samples through the controller under several register settings
// and compares every result with a cycle-free model of the bearing, distance
// and PID loops.
// Both stream sides idle at random. One long output stall backs up the input.
// ---------------------------------------------------------------------------
module go_to_goal_pid_controller_test;
    import g2g_pkg::*;

    localparam int STEPS = 16;
    localparam int FRAC  = 12;
    localparam longint THR_HEAD = (5 * (64'sd1 << FRAC) + 50) / 100;
    localparam longint THR_DIST = (10 * (64'sd1 << FRAC) + 50) / 100;
    localparam longint ARCTAN_Q30 [STEPS] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    typedef struct packed {
        logic        reached;
        logic [15:0] heading_error;
        logic [15:0] distance;
        logic [23:0] angular_speed;
        logic [23:0] linear_speed;
    } drive_t;

    class drive_scoreboard;
        logic [15:0] regs [8];
        longint      prior_range, dist_acc, last_err, err_acc;
        drive_t      pending [$];
        int          errors;

        function new();
            regs[REG_TARGET_X] = 16'd22528;
            regs[REG_TARGET_Y] = 16'd22528;
            regs[REG_DIST_KP]  = 16'd1229;
            regs[REG_DIST_KI]  = 16'd0;
            regs[REG_DIST_KD]  = 16'd410;
            regs[REG_HEAD_KP]  = 16'd4096;
            regs[REG_HEAD_KI]  = 16'd0;
            regs[REG_HEAD_KD]  = 16'd0;
            prior_range = 0;
            dist_acc  = 0;
            last_err  = 0;
            err_acc   = 0;
            errors    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            regs[idx] = val;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        static function longint root_floor(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        static function longint bearing_of(longint dx, longint dy);
            longint x, y, z, nx;
            x = dx * 16384;
            y = dy * 16384;
            z = 0;
            if (dx == 0 && dy == 0) return 0;
            if (x < 0) begin
                z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ARCTAN_Q30[i];
                end else begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ARCTAN_Q30[i];
                end
                x = nx;
            end
            return (z + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
        endfunction

        static function longint loop_drive(logic [15:0] kp, logic [15:0] ki,
                                           logic [15:0] kd, longint e,
                                           longint prev, longint acc);
            longint s;
            s = longint'($signed(kp)) * e + longint'($signed(kd)) * (e - prev)
              + longint'($signed(ki)) * acc;
            return clamp(s >>> FRAC, -8388608, 8388607);
        endfunction

        function void note_pose(logic [47:0] data);
            longint dx, dy, dmag, err, lin, ang;
            drive_t r;
            dx = longint'(regs[REG_TARGET_X]) - longint'(data[15:0]);
            dy = longint'(regs[REG_TARGET_Y]) - longint'(data[31:16]);
            dmag = clamp(root_floor(longint'(dx * dx + dy * dy)), 0, 65535);
            err = clamp(bearing_of(dx, dy) - longint'($signed(data[46:32])),
                        -32768, 32767);
            lin = loop_drive(regs[REG_DIST_KP], regs[REG_DIST_KI], regs[REG_DIST_KD],
                             dmag, prior_range, dist_acc);
            ang = loop_drive(regs[REG_HEAD_KP], regs[REG_HEAD_KI], regs[REG_HEAD_KD],
                             err, last_err, err_acc);
            prior_range = dmag;
            dist_acc  = clamp(dist_acc + dmag, -64'sd2147483648, 64'sd2147483647);
            last_err  = err;
            err_acc   = clamp(err_acc + err, -64'sd2147483648, 64'sd2147483647);
            r.linear_speed  = lin[23:0];
            r.angular_speed = ang[23:0];
            r.distance      = dmag[15:0];
            r.heading_error = err[15:0];
            r.reached       = (err > -THR_HEAD) && (err < THR_HEAD) && (dmag < THR_DIST);
            pending.push_back(r);
        endfunction

        function void check_result(logic [87:0] data);
            drive_t got, exp_r;
            got = data[80:0];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.linear_speed !== exp_r.linear_speed) begin
                $display("%0t: linear_speed exp %h got %h", $time,
                         exp_r.linear_speed, got.linear_speed);
                errors++;
            end
            if (got.angular_speed !== exp_r.angular_speed) begin
                $display("%0t: angular_speed exp %h got %h", $time,
                         exp_r.angular_speed, got.angular_speed);
                errors++;
            end
            if (got.distance !== exp_r.distance) begin
                $display("%0t: distance exp %h got %h", $time,
                         exp_r.distance, got.distance);
                errors++;
            end
            if (got.heading_error !== exp_r.heading_error) begin
                $display("%0t: heading_error exp %h got %h", $time,
                         exp_r.heading_error, got.heading_error);
                errors++;
            end
            if (got.reached !== exp_r.reached) begin
                $display("%0t: reached exp %b got %b", $time,
                         exp_r.reached, got.reached);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    drive_scoreboard sb;
    bit valid_high;
    bit hold_req;
    int burst_left;

    go_to_goal_pid_controller DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_pose(logic [15:0] px, logic [15:0] py, logic [14:0] th);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, th, py, px};
        valid_high = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pose({1'b0, th, py, px});
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            valid_high = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drop_valid();
        if (valid_high) begin
            s_axis_tvalid <= 1'b0;
            valid_high = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        drop_valid();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] near_target(logic [15:0] t, int span);
        longint v;
        v = longint'(t) + $signed($urandom_range(0, 2 * span)) - span;
        return 16'(drive_scoreboard::clamp(v, 0, 65535));
    endfunction

    task automatic random_poses(int n);
        logic [15:0] px, py;
        logic [14:0] th;
        int kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                px = near_target(sb.regs[REG_TARGET_X], (kind < 3) ? 500 : 8);
                py = near_target(sb.regs[REG_TARGET_Y], (kind < 3) ? 500 : 8);
            end else if (kind < 8) begin
                px = 16'($urandom);
                py = 16'($urandom);
            end else begin
                px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                py = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
            end
            if ($urandom_range(0, 9) == 0) th = 15'($urandom);
            else th = 15'($signed($urandom_range(0, 25736)) - 12868);
            send_pose(px, py, th);
        end
    endtask

    task automatic random_gains();
        for (int r = 0; r < 8; r++) write_reg(r[2:0], 16'($urandom));
    endtask

    // output side: stall pattern changes every window; long hold on request
    initial begin
        int win, kind, hold;
        m_axis_tready <= 1'b0;
        win = 0;
        kind = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = 400;
            end
            if (win == 0) begin
                win = $urandom_range(20, 120);
                kind = $urandom_range(0, 3);
            end
            win--;
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                case (kind)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (win % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin
        sb = new();
        valid_high = 1'b0;
        hold_req = 1'b0;
        burst_left = 5;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_TARGET_X;
        i_cfg_data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, target at pose, extremes, all quadrants
        send_pose(16'd22528, 16'd22528, 15'sd0);
        send_pose(16'd22528, 16'd22528, 15'sd12868);
        send_pose(16'd22528, 16'd22528, -15'sd12868);
        send_pose(16'd22600, 16'd22500, 15'sd100);
        send_pose(16'd0, 16'd0, 15'sd0);
        send_pose(16'hFFFF, 16'hFFFF, 15'sd0);
        send_pose(16'hFFFF, 16'd0, 15'sd3216);
        send_pose(16'd0, 16'hFFFF, -15'sd3216);
        send_pose(16'hFFFF, 16'd22528, 15'sd0);
        send_pose(16'd22528, 16'hFFFF, 15'h4000);
        send_pose(16'd22528, 16'd0, 15'h3FFF);
        send_pose(16'd30000, 16'd10000, 15'sd0);
        drain();

        write_reg(REG_TARGET_X, 16'h0000);
        write_reg(REG_TARGET_Y, 16'hFFFF);
        write_reg(REG_DIST_KP, 16'h7FFF);
        write_reg(REG_DIST_KI, 16'h8000);
        write_reg(REG_DIST_KD, 16'h7FFF);
        write_reg(REG_HEAD_KP, 16'h8000);
        write_reg(REG_HEAD_KI, 16'h7FFF);
        write_reg(REG_HEAD_KD, 16'h8000);
        send_pose(16'hFFFF, 16'd0, 15'sd12868);
        send_pose(16'hFFFF, 16'd0, -15'sd12868);
        send_pose(16'd0, 16'hFFFF, 15'sd0);
        send_pose(16'd0, 16'd0, 15'h4000);
        send_pose(16'd10, 16'hFFF0, 15'sd0);
        drain();

        // long output stall while the input keeps offering
        hold_req = 1'b1;
        random_poses(60);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: random_gains();
                1: begin
                    write_reg(REG_TARGET_X, 16'($urandom));
                    write_reg(REG_TARGET_Y, 16'($urandom));
                end
                2: begin
                    write_reg(REG_DIST_KI, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
                    write_reg(REG_HEAD_KI, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
                end
                default: begin
                    write_reg(REG_TARGET_X, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                    write_reg(REG_TARGET_Y, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                    write_reg(REG_DIST_KP, 16'($urandom));
                    write_reg(REG_HEAD_KD, 16'($urandom));
                end
            endcase
            random_poses(120);
            drain();
        end

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### go_to_goal_pid_controller.f
design/g2g_pkg.sv
design/g2g_cordic_cell.sv
design/g2g_sqrt_cell.sv
design/go_to_goal_pid_controller.sv
test/go_to_goal_pid_controller_test.sv
